@@ src/lpc_pkg.sv @@
// Shared types and constants of the lubrication pump controller.
`default_nettype none

package lpc_pkg;

    localparam int unsigned CntW = 16;
    localparam logic [CntW-1:0] CntMax = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PULSE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OFF    = 2'd0,
        ST_OILING = 2'd1,
        ST_IDLE   = 2'd2
    } t_status;

    localparam logic [1:0] MODE_TIMED   = 2'd0;
    localparam logic [1:0] MODE_POWERED = 2'd1;
    localparam logic [1:0] MODE_UNITS   = 2'd2;

    localparam logic [1:0] REG_START_MODE  = 2'd0;
    localparam logic [1:0] REG_INTERVAL    = 2'd1;
    localparam logic [1:0] REG_TARGET      = 2'd2;
    localparam logic [1:0] REG_MOTOR_COUNT = 2'd3;

    localparam logic [1:0]      RstStartMode  = MODE_TIMED;
    localparam logic [CntW-1:0] RstInterval   = 16'd3600;
    localparam logic [CntW-1:0] RstTarget     = 16'd10;
    localparam logic [1:0]      RstMotorCount = 2'd0;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

@@ src/lpc_if.sv @@
// Valid/ready channels for command words and result words.
`default_nettype none

interface lpc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       motor_index;
    logic       machine_ready;

    modport source (output valid, op, motor_index, machine_ready, input ready);
    modport sink   (input valid, op, motor_index, machine_ready, output ready);
endinterface

interface lpc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  motors_running;
    logic        restart_monitoring;
    logic        start_accepted;
    logic [15:0] idle_seconds;

    modport source (output valid, status, motors_running, restart_monitoring,
                    start_accepted, idle_seconds, input ready);
    modport sink   (input valid, status, motors_running, restart_monitoring,
                    start_accepted, idle_seconds, output ready);
endinterface

`default_nettype wire

@@ src/lubrication_pump_controller.sv @@
// Lubrication pump controller: command decode, motor state and result register.
//
// Usage: command words (second tick, work pulse, start, stop) arrive on i_in,
// and every command word yields exactly one result word on o_out, in order.
// A command word is accepted when valid and ready are both high. It is first
// captured in an input register; on the next edge at which the output register
// is free or being emptied, the motor state is updated and the result is
// written to the output register, where it is shown from then on.
// Throughput is one word per cycle while the receiver does not stall: the
// state update is a single pass of short logic, so a following word sees the
// state the previous one left. When the receiver stalls, the result is held,
// one further word may wait in the input register, and only then does
// i_in.ready fall. Registers are written through the APB port (start mode,
// oil interval, work target, motor count); the user must write them only
// while no word is in flight, which the block itself does not enforce.
// Reset (synchronous, active low) stops every motor, sets status to off,
// clears all counters, empties both registers and restores register defaults.
`default_nettype none

module lubrication_pump_controller #(
    parameter int unsigned MAX_PUMP_MOTORS = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lpc_cmd_if.sink     i_in,
    lpc_res_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpc_pkg::*;

    // Configuration registers
    logic [1:0]      r_start_mode;
    logic [CntW-1:0] r_interval;
    logic [CntW-1:0] r_target;
    logic [1:0]      r_motor_count;

    // Input register
    logic r_s1_valid;
    t_op  r_op;
    logic r_idx;
    logic r_ready_flag;

    // Motor state
    t_status                         r_status;
    logic [MAX_PUMP_MOTORS-1:0]      r_run;
    logic [CntW-1:0]                 r_cnt [MAX_PUMP_MOTORS];
    logic [CntW-1:0]                 r_sec [MAX_PUMP_MOTORS];
    logic [CntW-1:0]                 r_idle;

    t_status                         n_status;
    logic [MAX_PUMP_MOTORS-1:0]      n_run;
    logic [CntW-1:0]                 n_cnt [MAX_PUMP_MOTORS];
    logic [CntW-1:0]                 n_sec [MAX_PUMP_MOTORS];
    logic [CntW-1:0]                 n_idle;

    // Output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [1:0]  r_out_running;
    logic        r_out_mon;
    logic        r_out_acc;
    logic [15:0] r_out_idle;

    logic                       s1_adv;
    logic [1:0]                 used_n;
    logic [MAX_PUMP_MOTORS-1:0] in_use;
    logic                       mon;
    logic                       acc;
    logic                       all_stopped;
    logic [1:0]                 run_bits;
    logic                       cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mode  <= RstStartMode;
            r_interval    <= RstInterval;
            r_target      <= RstTarget;
            r_motor_count <= RstMotorCount;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_START_MODE:  r_start_mode  <= pwdata[1:0];
                REG_INTERVAL:    r_interval    <= pwdata[15:0];
                REG_TARGET:      r_target      <= pwdata[15:0];
                REG_MOTOR_COUNT: r_motor_count <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_MODE:  prdata = {30'd0, r_start_mode};
            REG_INTERVAL:    prdata = {16'd0, r_interval};
            REG_TARGET:      prdata = {16'd0, r_target};
            REG_MOTOR_COUNT: prdata = {30'd0, r_motor_count};
            default:         prdata = 32'd0;
        endcase
    end

    // Handshake: the input register moves on whenever the output register is
    // free or being emptied.
    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op         <= t_op'(i_in.op);
            r_idx        <= i_in.motor_index;
            r_ready_flag <= i_in.machine_ready;
        end
    end

    // A motor count above the fitted maximum is clamped to it.
    assign used_n = (32'(r_motor_count) > MAX_PUMP_MOTORS) ?
                    2'(MAX_PUMP_MOTORS) : r_motor_count;

    always_comb begin
        for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
            in_use[i] = (i < int'(used_n));
        end
    end

    always_comb begin
        n_status = r_status;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_sec    = r_sec;
        n_idle   = r_idle;
        mon      = 1'b0;
        acc      = 1'b0;

        unique case (r_op)
            OP_TICK: begin
                for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                    if (in_use[i] && !r_run[i]) begin
                        n_sec[i] = sat_inc(r_sec[i]);
                    end
                end
                n_idle = sat_inc(r_idle);
                if (r_status != ST_OFF) begin
                    if (r_start_mode == MODE_TIMED) begin
                        for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                            if (in_use[i] && !r_run[i] && (n_sec[i] > r_interval)) begin
                                n_run[i] = 1'b1;
                                n_cnt[i] = '0;
                                n_sec[i] = '0;
                            end
                        end
                    end else if ((r_start_mode == MODE_POWERED ||
                                  r_start_mode == MODE_UNITS) &&
                                 r_ready_flag && (used_n != 2'd0)) begin
                        for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                            if (in_use[i]) begin
                                n_run[i] = 1'b1;
                                n_cnt[i] = '0;
                                n_sec[i] = '0;
                            end
                        end
                        n_status = ST_OILING;
                        mon      = 1'b1;
                        acc      = 1'b1;
                    end
                end
            end
            OP_PULSE: begin
                if (32'(r_idx) < 32'(used_n)) begin
                    for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                        if (i == int'(r_idx)) begin
                            n_cnt[i] = sat_inc(r_cnt[i]);
                            if ((n_cnt[i] >= r_target) && r_run[i]) begin
                                n_run[i] = 1'b0;
                                n_sec[i] = '0;
                            end
                        end
                    end
                    if (n_cnt[r_idx] >= r_target && !(|(n_run & in_use))) begin
                        mon      = (r_start_mode != MODE_TIMED);
                        n_idle   = '0;
                        n_status = ST_IDLE;
                    end
                end
            end
            OP_START: begin
                if (used_n != 2'd0) begin
                    for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                        if (in_use[i]) begin
                            n_run[i] = 1'b1;
                            n_cnt[i] = '0;
                            n_sec[i] = '0;
                        end
                    end
                    n_status = ST_OILING;
                    mon      = (r_start_mode != MODE_TIMED);
                    acc      = 1'b1;
                end
            end
            OP_STOP: begin
                for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                    if (in_use[i] && r_run[i]) begin
                        n_run[i] = 1'b0;
                        n_sec[i] = '0;
                    end
                end
                n_status = ST_OFF;
                n_idle   = '0;
            end
            default: ;
        endcase
    end

    assign all_stopped = !(|(n_run & in_use));

    // Only the first two motors have a place in the result word.
    always_comb begin
        run_bits = 2'b00;
        for (int i = 0; i < MAX_PUMP_MOTORS && i < 2; i++) begin
            run_bits[i] = n_run[i] && in_use[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_OFF;
            r_run    <= '0;
            r_idle   <= '0;
            for (int i = 0; i < MAX_PUMP_MOTORS; i++) begin
                r_cnt[i] <= '0;
                r_sec[i] <= '0;
            end
        end else if (r_s1_valid && s1_adv) begin
            r_status <= n_status;
            r_run    <= n_run;
            r_idle   <= n_idle;
            r_cnt    <= n_cnt;
            r_sec    <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_status  <= n_status;
            r_out_running <= run_bits;
            r_out_mon     <= mon;
            r_out_acc     <= acc;
            r_out_idle    <= all_stopped ? n_idle : 16'd0;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_out_status;
    assign o_out.motors_running     = r_out_running;
    assign o_out.restart_monitoring = r_out_mon;
    assign o_out.start_accepted     = r_out_acc;
    assign o_out.idle_seconds       = r_out_idle;

`ifndef SYNTHESIS
    a_acc_oiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_acc |-> r_out_status == ST_OILING)
        else $error("start accepted without oiling status");

    a_mon_not_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_mon |-> r_out_status != ST_OFF)
        else $error("restart monitoring while oiler is off");

    a_idle_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_idle != 16'd0) |-> r_out_running == 2'b00)
        else $error("idle seconds reported while a motor runs");

    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_op))
        else $error("pending command word lost");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_idle))
        else $error("stalled result word lost");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the pump controller: directed and random command words, checked by a predictor.
module testbench;
    import lpc_pkg::*;

    localparam int unsigned MaxMotors      = 2;
    localparam logic [1:0]  ModeReserved   = 2'd3;
    localparam int unsigned WordsPerBlock  = 25;
    localparam int unsigned BlocksPerPhase = 5;

    typedef struct packed {
        t_status     status;
        logic [1:0]  running;
        logic        monitor;
        logic        accepted;
        logic [15:0] idle_secs;
    } oiler_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lpc_cmd_if cmd_bus ();
    lpc_res_if res_bus ();

    lubrication_pump_controller #(
        .MAX_PUMP_MOTORS(MaxMotors)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_bus),
        .o_out  (res_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    oiler_word_t pending_words[$];

    // Register copy and oiler state as the predictor sees them.
    logic [1:0]  cfg_mode     = RstStartMode;
    logic [15:0] cfg_interval = RstInterval;
    logic [15:0] cfg_target   = RstTarget;
    logic [1:0]  cfg_motors   = RstMotorCount;
    t_status     oiler_state  = ST_OFF;
    logic        run_flag[MaxMotors]     = '{default: 1'b0};
    logic [15:0] pulse_count[MaxMotors]  = '{default: 16'd0};
    logic [15:0] stopped_secs[MaxMotors] = '{default: 16'd0};
    logic [15:0] idle_count = 16'd0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] count_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic all_stopped(input int unsigned used);
        int unsigned m;
        for (m = 0; m < used; m++) begin
            if (run_flag[m]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void start_oiler(input int unsigned used, inout logic mon,
                                        inout logic acc);
        int unsigned m;
        if (used != 0) begin
            for (m = 0; m < used; m++) begin
                run_flag[m]     = 1'b1;
                pulse_count[m]  = 16'd0;
                stopped_secs[m] = 16'd0;
            end
            if (cfg_mode != MODE_TIMED) begin
                mon = 1'b1;
            end
            oiler_state = ST_OILING;
            acc = 1'b1;
        end
    endfunction

    // Applies one command word to the oiler state and returns the word it should produce.
    function automatic oiler_word_t advance_oiler(input t_op op, input logic idx,
                                                  input logic mready);
        int unsigned used;
        int unsigned m;
        logic        mon;
        logic        acc;
        oiler_word_t w;
        used = (cfg_motors > MaxMotors) ? MaxMotors : cfg_motors;
        mon  = 1'b0;
        acc  = 1'b0;
        w    = '0;
        case (op)
            OP_TICK: begin
                for (m = 0; m < used; m++) begin
                    if (!run_flag[m]) begin
                        stopped_secs[m] = count_up(stopped_secs[m]);
                    end
                end
                idle_count = count_up(idle_count);
                if (oiler_state != ST_OFF) begin
                    if (cfg_mode == MODE_TIMED) begin
                        for (m = 0; m < used; m++) begin
                            if (!run_flag[m] && stopped_secs[m] > cfg_interval) begin
                                run_flag[m]     = 1'b1;
                                pulse_count[m]  = 16'd0;
                                stopped_secs[m] = 16'd0;
                            end
                        end
                    end else if (cfg_mode == MODE_POWERED || cfg_mode == MODE_UNITS) begin
                        if (mready) begin
                            start_oiler(used, mon, acc);
                        end
                    end
                end
            end
            OP_PULSE: begin
                if (idx < used) begin
                    pulse_count[idx] = count_up(pulse_count[idx]);
                    if (pulse_count[idx] >= cfg_target) begin
                        if (run_flag[idx]) begin
                            run_flag[idx]     = 1'b0;
                            stopped_secs[idx] = 16'd0;
                        end
                        if (all_stopped(used)) begin
                            mon         = (cfg_mode != MODE_TIMED);
                            idle_count  = 16'd0;
                            oiler_state = ST_IDLE;
                        end
                    end
                end
            end
            OP_START: begin
                start_oiler(used, mon, acc);
            end
            default: begin
                for (m = 0; m < used; m++) begin
                    if (run_flag[m]) begin
                        run_flag[m]     = 1'b0;
                        stopped_secs[m] = 16'd0;
                    end
                end
                oiler_state = ST_OFF;
                idle_count  = 16'd0;
            end
        endcase
        for (m = 0; m < used; m++) begin
            if (run_flag[m]) begin
                w.running[m] = 1'b1;
            end
        end
        w.status    = oiler_state;
        w.monitor   = mon;
        w.accepted  = acc;
        w.idle_secs = all_stopped(used) ? idle_count : 16'd0;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        oiler_word_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("result word with none pending", 1, 0);
            end else begin
                want = pending_words.pop_front();
                if (res_bus.status !== want.status)
                    report_mismatch("status", res_bus.status, want.status);
                if (res_bus.motors_running !== want.running)
                    report_mismatch("motors_running", res_bus.motors_running, want.running);
                if (res_bus.restart_monitoring !== want.monitor)
                    report_mismatch("restart_monitoring", res_bus.restart_monitoring,
                                    want.monitor);
                if (res_bus.start_accepted !== want.accepted)
                    report_mismatch("start_accepted", res_bus.start_accepted, want.accepted);
                if (res_bus.idle_seconds !== want.idle_secs)
                    report_mismatch("idle_seconds", res_bus.idle_seconds, want.idle_secs);
            end
        end
    end

    // The word stays on the bus after acceptance so that the next one can follow at once.
    task automatic send_word(input t_op op, input logic idx, input logic mready);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.op            <= op;
        cmd_bus.motor_index   <= idx;
        cmd_bus.machine_ready <= mready;
        do @(posedge i_clk); while (!cmd_bus.ready);
        pending_words.push_back(advance_oiler(op, idx, mready));
    endtask

    task automatic drain_words();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] reg_index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            REG_START_MODE: cfg_mode     = value[1:0];
            REG_INTERVAL:   cfg_interval = value[15:0];
            REG_TARGET:     cfg_target   = value[15:0];
            default:        cfg_motors   = value[1:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_oiler(input logic [1:0] mode, input logic [15:0] interval,
                             input logic [15:0] target, input logic [1:0] motors);
        drain_words();
        reg_write(REG_START_MODE, {30'd0, mode});
        reg_write(REG_INTERVAL, {16'd0, interval});
        reg_write(REG_TARGET, {16'd0, target});
        reg_write(REG_MOTOR_COUNT, {30'd0, motors});
    endtask

    // With no motor fitted a start has no effect, though ticks still count idle seconds.
    task automatic test_register_defaults();
        send_word(OP_START, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b1, 1'b1);
        send_word(OP_PULSE, 1'b0, 1'b0);
        send_word(OP_STOP, 1'b0, 1'b0);
    endtask

    task automatic test_timed_restart();
        set_oiler(MODE_TIMED, 16'd1, 16'd1, 2'd2);
        send_word(OP_START, 1'b0, 1'b0);
        send_word(OP_PULSE, 1'b0, 1'b0);
        send_word(OP_PULSE, 1'b1, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b1, 1'b0);
        send_word(OP_PULSE, 1'b0, 1'b1);
        send_word(OP_STOP, 1'b1, 1'b1);
    endtask

    task automatic test_machine_start();
        set_oiler(MODE_POWERED, 16'hFFFF, 16'hFFFF, 2'd1);
        send_word(OP_TICK, 1'b0, 1'b1);
        send_word(OP_START, 1'b0, 1'b0);
        send_word(OP_PULSE, 1'b1, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b1);
        set_oiler(MODE_UNITS, 16'd0, 16'd1, 2'd2);
        send_word(OP_START, 1'b1, 1'b1);
        send_word(OP_PULSE, 1'b0, 1'b0);
        send_word(OP_PULSE, 1'b0, 1'b0);
        send_word(OP_PULSE, 1'b1, 1'b0);
        send_word(OP_TICK, 1'b1, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b1);
    endtask

    // Motor count above the fitted maximum, a zero target and the reserved mode together.
    task automatic test_corner_cases();
        set_oiler(ModeReserved, 16'd0, 16'd0, 2'd3);
        send_word(OP_START, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b1);
        send_word(OP_PULSE, 1'b1, 1'b0);
        send_word(OP_PULSE, 1'b0, 1'b0);
        send_word(OP_STOP, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned blk;
        int unsigned n;
        int unsigned pick;
        logic [1:0]  mode;
        logic [15:0] interval;
        logic [15:0] target;
        logic [1:0]  motors;
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        for (blk = 0; blk < BlocksPerPhase; blk++) begin
            mode = ($urandom_range(7) == 0) ? ModeReserved : 2'($urandom_range(2));
            pick = $urandom_range(9);
            interval = (pick == 0) ? 16'hFFFF :
                       (pick == 1) ? 16'($urandom_range(65535)) : 16'($urandom_range(4));
            pick = $urandom_range(9);
            target = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
            pick = $urandom_range(9);
            motors = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : 2'($urandom_range(1, 2));
            set_oiler(mode, interval, target, motors);
            // Most words follow a start, so the pulses and ticks act on a running oiler.
            send_word(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (n = 0; n < WordsPerBlock; n++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    send_word(OP_PULSE, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end else if (pick < 85) begin
                    send_word(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end else if (pick < 93) begin
                    send_word(OP_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    send_word(OP_STOP, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = 4'd0;
        pwdata                = 32'd0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.op            = OP_TICK;
        cmd_bus.motor_index   = 1'b0;
        cmd_bus.machine_ready = 1'b0;
        res_bus.ready         = 1'b0;
        mismatches            = 0;
        send_gap_pct          = 23;
        recv_stall_pct        = 77;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_defaults();
        test_timed_restart();
        test_machine_start();
        test_corner_cases();
        test_random_traffic(23, 77);
        test_random_traffic(77, 23);
        test_random_traffic(0, 0);
        drain_words();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/lpc_pkg.sv
src/lpc_if.sv
src/lubrication_pump_controller.sv
tb/testbench.sv
